// ===== hw/rtl/rme_pkg.sv =====
package rme_pkg;

    localparam int unsigned DefCordicSteps = 16;
    localparam int unsigned MaxCordicSteps = 24;
    localparam int unsigned SqrtSteps      = 16;
    localparam int unsigned MatW           = 16;
    localparam int unsigned ThrW           = 15;
    localparam int unsigned AngW           = 16;
    localparam int unsigned CorXW          = 36;
    localparam int unsigned CorZW          = 28;

    localparam logic signed [CorZW-1:0] PiAngle = 28'sd52707179;

    typedef struct packed {
        logic signed [MatW-1:0] m00;
        logic signed [MatW-1:0] m10;
        logic signed [MatW-1:0] m20;
        logic signed [MatW-1:0] m21;
        logic signed [MatW-1:0] m22;
        logic signed [MatW-1:0] m11;
        logic signed [MatW-1:0] m12;
    } t_mat;

    // round(atan(2^-i) * 2^24)
    function automatic logic signed [CorZW-1:0] angle_step(input logic [4:0] idx);
        logic signed [CorZW-1:0] v;
        case (idx)
            5'd0:    v = 28'sd13176795;
            5'd1:    v = 28'sd7778716;
            5'd2:    v = 28'sd4110060;
            5'd3:    v = 28'sd2086331;
            5'd4:    v = 28'sd1047214;
            5'd5:    v = 28'sd524117;
            5'd6:    v = 28'sd262123;
            5'd7:    v = 28'sd131069;
            5'd8:    v = 28'sd65536;
            5'd9:    v = 28'sd32768;
            5'd10:   v = 28'sd16384;
            5'd11:   v = 28'sd8192;
            5'd12:   v = 28'sd4096;
            5'd13:   v = 28'sd2048;
            5'd14:   v = 28'sd1024;
            5'd15:   v = 28'sd512;
            5'd16:   v = 28'sd256;
            5'd17:   v = 28'sd128;
            5'd18:   v = 28'sd64;
            5'd19:   v = 28'sd32;
            5'd20:   v = 28'sd16;
            5'd21:   v = 28'sd8;
            5'd22:   v = 28'sd4;
            5'd23:   v = 28'sd2;
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

// ===== hw/rtl/rme_sqrt.sv =====
module rme_sqrt
    import rme_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    input  logic [31:0] i_radicand,
    input  t_mat        i_side,
    output logic        o_valid,
    output logic [15:0] o_root,
    output t_mat        o_side
);

    // One result bit per stage, restoring digit-by-digit square root.
    logic        r_valid [0:SqrtSteps-1];
    logic [17:0] r_rem   [0:SqrtSteps-1];
    logic [15:0] r_root  [0:SqrtSteps-1];
    logic [31:0] r_rad   [0:SqrtSteps-1];
    t_mat        r_side  [0:SqrtSteps-1];

    genvar k;
    generate
        for (k = 0; k < SqrtSteps; k++) begin : g_stage
            logic        p_valid;
            logic [17:0] p_rem;
            logic [15:0] p_root;
            logic [31:0] p_rad;
            t_mat        p_side;
            logic [19:0] cur;
            logic [19:0] trial;
            logic [17:0] n_rem;
            logic [15:0] n_root;

            if (k == 0) begin : g_first
                assign p_valid = i_valid;
                assign p_rem   = '0;
                assign p_root  = '0;
                assign p_rad   = i_radicand;
                assign p_side  = i_side;
            end else begin : g_next
                assign p_valid = r_valid[k-1];
                assign p_rem   = r_rem[k-1];
                assign p_root  = r_root[k-1];
                assign p_rad   = r_rad[k-1];
                assign p_side  = r_side[k-1];
            end

            always_comb begin
                cur   = {p_rem, p_rad[31:30]};
                trial = {2'b00, p_root, 2'b01};
                if (cur >= trial) begin
                    n_rem  = 18'(cur - trial);
                    n_root = {p_root[14:0], 1'b1};
                end else begin
                    n_rem  = cur[17:0];
                    n_root = {p_root[14:0], 1'b0};
                end
            end

            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_valid[k] <= 1'b0;
                end else begin
                    r_valid[k] <= p_valid;
                end
                r_rem[k]  <= n_rem;
                r_root[k] <= n_root;
                r_rad[k]  <= {p_rad[29:0], 2'b00};
                r_side[k] <= p_side;
            end
        end
    endgenerate

    assign o_valid = r_valid[SqrtSteps-1];
    assign o_root  = r_root[SqrtSteps-1];
    assign o_side  = r_side[SqrtSteps-1];

endmodule

// ===== hw/rtl/rme_cordic.sv =====
module rme_cordic
    import rme_pkg::*;
#(
    parameter int unsigned STEPS = DefCordicSteps
) (
    input  logic                   i_clk,
    input  logic signed [16:0]     i_y,
    input  logic signed [16:0]     i_x,
    output logic signed [AngW-1:0] o_angle
);

    logic signed [CorXW-1:0] r_x    [0:STEPS];
    logic signed [CorXW-1:0] r_y    [0:STEPS];
    logic signed [CorZW-1:0] r_z    [0:STEPS];
    logic                    r_zero [0:STEPS];

    logic signed [CorXW-1:0] xs;
    logic signed [CorXW-1:0] ys;
    logic signed [CorZW-1:0] zr;

    assign xs = {{3{i_x[16]}}, i_x, 16'h0000};
    assign ys = {{3{i_y[16]}}, i_y, 16'h0000};

    // Vectors in the left half-plane are turned by pi before the iterations.
    always_ff @(posedge i_clk) begin
        r_zero[0] <= (i_x == '0) && (i_y == '0);
        if (i_x[16]) begin
            r_x[0] <= -xs;
            r_y[0] <= -ys;
            r_z[0] <= i_y[16] ? -PiAngle : PiAngle;
        end else begin
            r_x[0] <= xs;
            r_y[0] <= ys;
            r_z[0] <= '0;
        end
    end

    genvar k;
    generate
        for (k = 0; k < STEPS; k++) begin : g_iter
            logic signed [CorXW-1:0] dx;
            logic signed [CorXW-1:0] dy;
            logic signed [CorZW-1:0] da;
            assign dx = r_y[k] >>> k;
            assign dy = r_x[k] >>> k;
            assign da = angle_step(5'(k));
            always_ff @(posedge i_clk) begin
                r_zero[k+1] <= r_zero[k];
                if (!r_y[k][CorXW-1]) begin
                    r_x[k+1] <= r_x[k] + dx;
                    r_y[k+1] <= r_y[k] - dy;
                    r_z[k+1] <= r_z[k] + da;
                end else begin
                    r_x[k+1] <= r_x[k] - dx;
                    r_y[k+1] <= r_y[k] + dy;
                    r_z[k+1] <= r_z[k] - da;
                end
            end
        end
    endgenerate

    // Round half up from 2^-24 to 2^-13 radians.
    assign zr      = r_z[STEPS] + 28'sd1024;
    assign o_angle = r_zero[STEPS] ? '0 : zr[26:11];

endmodule

// ===== hw/rtl/rotation_matrix_to_euler.sv =====
// Converts a rotation matrix (Q1.14 entries) to x-y-z Euler angles in Q2.13
// radians. The block is fully pipelined: it takes one matrix per clock cycle
// and never raises busy. Each result appears on the o_valid strobe after the
// start transfer has passed the registers for the squares and their sum, the
// one-bit-per-stage square root, the input register and iteration stages of
// the three parallel CORDIC pipelines, and the output register. The receiver
// cannot stall the block, so results must be taken as they come. The
// threshold register accepts a transfer in any cycle but must only be changed
// while no matrix is in flight.
module rotation_matrix_to_euler
    import rme_pkg::*;
#(
    parameter int unsigned CORDIC_STEPS = DefCordicSteps
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   start,
    output logic                   busy,
    input  logic signed [MatW-1:0] i_m00,
    input  logic signed [MatW-1:0] i_m10,
    input  logic signed [MatW-1:0] i_m20,
    input  logic signed [MatW-1:0] i_m21,
    input  logic signed [MatW-1:0] i_m22,
    input  logic signed [MatW-1:0] i_m11,
    input  logic signed [MatW-1:0] i_m12,
    input  logic                   i_cfg_valid,
    output logic                   o_cfg_ready,
    input  logic [ThrW-1:0]        i_cfg_data,
    output logic                   o_valid,
    output logic signed [AngW-1:0] o_roll,
    output logic signed [AngW-1:0] o_pitch,
    output logic signed [AngW-1:0] o_yaw,
    output logic                   o_singular
);

    localparam int unsigned Steps   = (CORDIC_STEPS > MaxCordicSteps) ? MaxCordicSteps
                                                                      : CORDIC_STEPS;
    localparam int unsigned Latency = Steps + 20;

    logic [ThrW-1:0] r_thr;

    logic            r_v1, r_v2;
    logic [31:0]     r_sq00, r_sq10, r_sum;
    t_mat            r_m1, r_m2;

    logic            sq_valid;
    logic [15:0]     sq_root;
    t_mat            sq_m;
    logic            sing;

    logic signed [16:0] roll_y, roll_x, pitch_y, pitch_x, yaw_y, yaw_x;
    logic signed [AngW-1:0] roll_a, pitch_a, yaw_a;

    logic            r_dv   [0:Steps];
    logic            r_ds   [0:Steps];

    logic                   r_valid;
    logic signed [AngW-1:0] r_roll, r_pitch, r_yaw;
    logic                   r_sing;

    assign busy        = 1'b0;
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr <= ThrW'(1);
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_thr <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            r_v1 <= start && !busy;
            r_v2 <= r_v1;
        end
        r_sq00 <= 32'(i_m00 * i_m00);
        r_sq10 <= 32'(i_m10 * i_m10);
        r_m1   <= '{i_m00, i_m10, i_m20, i_m21, i_m22, i_m11, i_m12};
        r_sum  <= r_sq00 + r_sq10;
        r_m2   <= r_m1;
    end

    rme_sqrt u_sqrt (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (r_v2),
        .i_radicand (r_sum),
        .i_side     (r_m2),
        .o_valid    (sq_valid),
        .o_root     (sq_root),
        .o_side     (sq_m)
    );

    assign sing    = sq_root < {1'b0, r_thr};
    assign pitch_y = -$signed({sq_m.m20[15], sq_m.m20});
    assign pitch_x = $signed({1'b0, sq_root});
    assign yaw_y   = {sq_m.m10[15], sq_m.m10};
    assign yaw_x   = {sq_m.m00[15], sq_m.m00};

    always_comb begin
        if (sing) begin
            roll_y = -$signed({sq_m.m12[15], sq_m.m12});
            roll_x = {sq_m.m11[15], sq_m.m11};
        end else begin
            roll_y = {sq_m.m21[15], sq_m.m21};
            roll_x = {sq_m.m22[15], sq_m.m22};
        end
    end

    rme_cordic #(.STEPS(Steps)) u_roll (
        .i_clk(i_clk), .i_y(roll_y), .i_x(roll_x), .o_angle(roll_a)
    );
    rme_cordic #(.STEPS(Steps)) u_pitch (
        .i_clk(i_clk), .i_y(pitch_y), .i_x(pitch_x), .o_angle(pitch_a)
    );
    rme_cordic #(.STEPS(Steps)) u_yaw (
        .i_clk(i_clk), .i_y(yaw_y), .i_x(yaw_x), .o_angle(yaw_a)
    );

    // Valid and branch flag follow the CORDIC stages.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dv[0] <= 1'b0;
        end else begin
            r_dv[0] <= sq_valid;
        end
        r_ds[0] <= sing;
    end

    genvar k;
    generate
        for (k = 0; k < Steps; k++) begin : g_dly
            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_dv[k+1] <= 1'b0;
                end else begin
                    r_dv[k+1] <= r_dv[k];
                end
                r_ds[k+1] <= r_ds[k];
            end
        end
    endgenerate

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= r_dv[Steps];
        end
        r_roll  <= roll_a;
        r_pitch <= pitch_a;
        r_yaw   <= r_ds[Steps] ? '0 : yaw_a;
        r_sing  <= r_ds[Steps];
    end

    assign o_valid    = r_valid;
    assign o_roll     = r_roll;
    assign o_pitch    = r_pitch;
    assign o_yaw      = r_yaw;
    assign o_singular = r_sing;

    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start |-> ##(Latency) o_valid)
        else $error("result strobe missing after start transfer");

    a_yaw_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_singular |-> o_yaw == '0)
        else $error("yaw not zero in singular branch");

    a_sqrt_aligned: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v2 |-> ##(SqrtSteps) sq_valid)
        else $error("square root stage lost an item");

    a_roll_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_roll <= 16'sd26000) && (o_roll >= -16'sd26000))
        else $error("roll outside angle range");

endmodule
